// File: sv/pdc_pkg.sv
// Shared types and codes for the pixel depth converter.
// No dependencies; imported by every module of the block.
`default_nettype none
package pdc_pkg;

    localparam int PAL_DEPTH  = 256;
    localparam int PAL_ADDR_W = 8;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [2:0] {
        FMT_IDX = 3'd0,
        FMT_565 = 3'd1,
        FMT_24  = 3'd2,
        FMT_32  = 3'd3,
        FMT_GL  = 3'd4
    } fmt_t;

    typedef enum logic [1:0] {
        CMD_CONVERT = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE = 2'd0,
        CFG_TARGET = 2'd1,
        CFG_SPARE2 = 2'd2,
        CFG_SPARE3 = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr;
        rgb_t                  color;
    } pal_wr_t;

    typedef struct packed {
        cmd_t                  command;
        logic [31:0]           pixel;
        logic [PAL_ADDR_W-1:0] index;
        rgb_t                  entry;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel;
        rgb_t        rd;
        logic        err;
    } result_t;

endpackage
`default_nettype wire

// File: sv/pdc_palette.sv
// 256-entry color palette: one write port, one registered read port.
// Per-entry valid bits give the all-zero reset; writes forward to a read
// issued in the same cycle. Depends on pdc_pkg.
`default_nettype none
module pdc_palette (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pdc_pkg::pal_wr_t               wr,
    input  wire logic                           rd_en,
    input  wire logic [pdc_pkg::PAL_ADDR_W-1:0] rd_addr,
    output pdc_pkg::rgb_t                       rd_color
);
    import pdc_pkg::*;

    rgb_t                 mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] valid_reg;
    rgb_t                 rd_data_reg;
    logic                 rd_valid_reg;
    logic                 fwd;

    assign fwd = wr.en && (wr.addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= fwd ? wr.color : mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= fwd || valid_reg[rd_addr];
            end
        end
    end

    assign rd_color = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

// File: sv/pdc_convert.sv
// Combinational conversion datapath for one item: decode, color expand,
// target pack, palette write request. Depends on pdc_pkg.
`default_nettype none
module pdc_convert (
    input  wire pdc_pkg::item_t   item,
    input  wire pdc_pkg::fmt_t    src,
    input  wire pdc_pkg::fmt_t    tgt,
    input  wire pdc_pkg::rgb_t    pal_color,
    output pdc_pkg::result_t      result,
    output pdc_pkg::pal_wr_t      wr
);
    import pdc_pkg::*;

    logic       src_ok;
    logic       tgt_ok;
    rgb_t       c;
    logic [7:0] k;

    always_comb
    begin
        case (src)
            FMT_IDX, FMT_565, FMT_24, FMT_32: src_ok = 1'b1;
            default:                          src_ok = 1'b0;
        endcase
        case (tgt)
            FMT_IDX, FMT_565, FMT_24, FMT_32: tgt_ok = 1'b1;
            default:                          tgt_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        case (src)
            FMT_IDX: c = pal_color;
            FMT_565:
            begin
                c.red   = {item.pixel[15:11], 3'b000};
                c.green = {item.pixel[10:5], 2'b00};
                c.blue  = {item.pixel[4:0], 3'b000};
            end
            default:
            begin
                c.red   = item.pixel[7:0];
                c.green = item.pixel[15:8];
                c.blue  = item.pixel[23:16];
            end
        endcase
    end

    // 3-2-3 index: red in 2:0, green in 4:3, blue in 7:5
    assign k = {c.blue[7:5], c.green[7:6], c.red[7:5]};

    always_comb
    begin
        result   = '0;
        wr       = '0;
        wr.addr  = item.index;
        wr.color = item.entry;
        case (item.command)
            CMD_WRITE: wr.en = 1'b1;
            CMD_READ:  result.rd = pal_color;
            CMD_CONVERT:
            begin
                if (!src_ok || !tgt_ok)
                begin
                    result.err = 1'b1;
                end
                else if (src == tgt)
                begin
                    case (src)
                        FMT_IDX: result.pixel = {24'h0, item.pixel[7:0]};
                        FMT_565: result.pixel = {16'h0, item.pixel[15:0]};
                        FMT_24:  result.pixel = {8'h0, item.pixel[23:0]};
                        default: result.pixel = item.pixel;
                    endcase
                end
                else
                begin
                    case (tgt)
                        FMT_IDX:
                        begin
                            wr.en         = 1'b1;
                            wr.addr       = k;
                            wr.color      = c;
                            result.pixel  = {24'h0, k};
                        end
                        FMT_565:
                            result.pixel = {16'h0, c.red[7:3], c.green[7:2], c.blue[7:3]};
                        default:
                        begin
                            if (tgt == FMT_32 && src == FMT_IDX)
                                result.pixel = {8'h0, c.red, c.green, c.blue};
                            else
                                result.pixel = {8'h0, c.blue, c.green, c.red};
                        end
                    endcase
                end
            end
            default: result = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/pixel_depth_converter.sv
// Pixel depth converter top level: config registers, item register,
// palette and result register. Depends on pdc_pkg, pdc_palette, pdc_convert.
// Item accept loads the item register and the palette read; the convert
// result enters the result register when the item advances, which stalls while a result waits on out_ready.
// Throughput: one item per cycle while out_ready is high.
// Reset clears formats to indexed, all palette entries to zero and the
// pipeline to empty; no clearing pass is needed.
`default_nettype none
module pixel_depth_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] in_pixel,
    input  wire logic [7:0]  entry_index,
    input  wire logic [7:0]  entry_red,
    input  wire logic [7:0]  entry_green,
    input  wire logic [7:0]  entry_blue,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_pixel,
    output logic [7:0]       read_red,
    output logic [7:0]       read_green,
    output logic [7:0]       read_blue,
    output logic             format_error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pdc_pkg::*;

    fmt_t    src_reg;
    fmt_t    tgt_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;

    logic    accept;
    logic    advance;
    rgb_t    pal_color;
    result_t res_next;
    pal_wr_t wr_req;
    pal_wr_t wr;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= FMT_IDX;
            tgt_reg <= FMT_IDX;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SOURCE: src_reg <= fmt_t'(cfg_data[2:0]);
                CFG_TARGET: tgt_reg <= fmt_t'(cfg_data[2:0]);
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command <= cmd_t'(command);
            item_reg.pixel   <= in_pixel;
            item_reg.index   <= entry_index;
            item_reg.entry   <= '{red: entry_red, green: entry_green, blue: entry_blue};
        end
        if (advance)
            res_reg <= res_next;
    end

    // palette writes commit only when the item moves on, so a held item
    // never writes twice
    always_comb
    begin
        wr    = wr_req;
        wr.en = wr_req.en && advance;
    end

    pdc_palette u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_en    (accept),
        .rd_addr  ((cmd_t'(command) == CMD_READ) ? entry_index : in_pixel[7:0]),
        .rd_color (pal_color)
    );

    pdc_convert u_convert (
        .item      (item_reg),
        .src       (src_reg),
        .tgt       (tgt_reg),
        .pal_color (pal_color),
        .result    (res_next),
        .wr        (wr_req)
    );

    assign out_valid    = res_valid_reg;
    assign out_pixel    = res_reg.pixel;
    assign read_red     = res_reg.rd.red;
    assign read_green   = res_reg.rd.green;
    assign read_blue    = res_reg.rd.blue;
    assign format_error = res_reg.err;

endmodule
`default_nettype wire
